@@ sv/keyed_record_list_defines.svh @@
// ----------------------------------------------------------------------------
// keyed_record_list_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_LIST_DEFINES_SVH
`define KEYED_RECORD_LIST_DEFINES_SVH

// property must hold at every clock edge outside reset
`define KRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define KRL_ASSERT_NEVER(label, expr, msg) \
  `KRL_ASSERT(label, !(expr), msg)

`endif

@@ sv/krl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_pkg: keyed record list types and constants
// Transaction structs, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package krl_pkg;

  localparam int CapacityDef = 16;
  localparam int KeyW        = 32;
  localparam int PayloadW    = 64;
  localparam int CountW      = 5;
  localparam int ModeW       = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]           mode;
    logic signed [KeyW-1:0]     record_key;
    logic [PayloadW-1:0]        record_payload;
  } req_t;

  typedef struct packed {
    logic                       success;
    logic [PayloadW-1:0]        found_payload;
    logic [CountW-1:0]          entry_count;
    logic                       is_full;
    logic                       is_empty;
  } rsp_t;

endpackage

@@ sv/krl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krl_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module krl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/keyed_record_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_list: fixed-capacity packed list of keyed records
// Append, lookup and remove over a record RAM under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start; the transaction is taken at a clock edge
//   with start high and busy low. busy stays high while an operation runs.
//   Each transaction yields one response on rsp_o, marked by done_o for
//   exactly one cycle; the receiver must take it then.
// Operation flow (accept edge to the edge that takes the response):
//   append            : written at the accept edge, a new transaction may follow at once
//   lookup            : entries are scanned in order until a key match or the count
//   remove            : scan as lookup; on a match the entries above it are moved
//                       down one place and the count lowered
// The single RAM port pair sets this pace: one entry is read per cycle,
// and during a remove each entry is read and written back one place lower.
// Reset clears the record count; record storage holds no reset value and
// entries at or beyond the count are never read out.
// ----------------------------------------------------------------------------
`include "keyed_record_list_defines.svh"

module keyed_record_list #(
  parameter int CAPACITY = krl_pkg::CapacityDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  krl_pkg::req_t req_i,
  output logic          done_o,
  output krl_pkg::rsp_t rsp_o
);

  import krl_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int RecW = KeyW + PayloadW;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [KeyW-1:0]   key_q;
  logic              remove_q;
  logic              done_q;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic              hit;
  logic              at_end;
  logic              finish;
  logic              ok;
  logic [PayloadW-1:0] found;
  logic [CW-1:0]     wr_idx;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RecW-1:0]   ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [RecW-1:0]   ram_rdata;

  krl_ram #(
    .Width (RecW),
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign hit    = pend_q && (ram_rdata[RecW-1:PayloadW] == key_q);
  assign at_end = (idx_q == cnt_q);
  assign wr_idx = idx_q - CW'(2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.mode inside {MODE_LOOKUP, MODE_REMOVE})) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = remove_q ? ST_SHIFT : ST_IDLE;
        end else if (at_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (at_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    finish    = 1'b0;
    ok        = 1'b0;
    found     = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = {req_i.record_key, req_i.record_payload};
    ram_raddr = idx_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_APPEND: begin
              finish = 1'b1;
              if (cnt_q < CapCnt) begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
                ok     = 1'b1;
              end
            end
            MODE_LOOKUP, MODE_REMOVE: begin
              idx_d = '0;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (!remove_q) begin
            finish = 1'b1;
            ok     = 1'b1;
            found  = ram_rdata[PayloadW-1:0];
          end
        end else if (at_end) begin
          finish = 1'b1;
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + CW'(1);
        end
      end
      ST_SHIFT: begin
        // rdata holds entry idx-1, moved down to idx-2
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (at_end) begin
          finish = 1'b1;
          ok     = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_d.success       = ok;
    rsp_d.found_payload = found;
    rsp_d.entry_count   = CountW'(cnt_d);
    rsp_d.is_full       = (cnt_d == CapCnt);
    rsp_d.is_empty      = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      done_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= req_i.record_key;
      remove_q <= (req_i.mode == MODE_REMOVE);
    end
    if (finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `KRL_ASSERT(a_count_in_range, cnt_q <= CapCnt, "record count above capacity")
  `KRL_ASSERT_NEVER(a_done_while_busy, done_o && busy, "response while still busy")
  `KRL_ASSERT_NEVER(a_full_and_empty, done_o && rsp_o.is_full && rsp_o.is_empty,
                    "full and empty reported together")
  `KRL_ASSERT(a_append_room,
              (accept && req_i.mode == MODE_APPEND && cnt_q < CapCnt) |=> (done_o && rsp_o.success),
              "append with room did not succeed")

endmodule
